// ===== hdl/rrts_pkg.sv =====
`timescale 1ns / 1ps
package rrts_pkg;

  // Slot status codes
  localparam logic [2:0] SLOT_UNUSED     = 3'd0;
  localparam logic [2:0] SLOT_READY      = 3'd1;
  localparam logic [2:0] SLOT_RUNNING    = 3'd2;
  localparam logic [2:0] SLOT_BLOCKED    = 3'd3;
  localparam logic [2:0] SLOT_TERMINATED = 3'd4;

  // Action codes
  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_CREATE    = 3'd1;
  localparam logic [2:0] ACT_EXIT      = 3'd2;
  localparam logic [2:0] ACT_TERMINATE = 3'd3;
  localparam logic [2:0] ACT_WAIT      = 3'd4;
  localparam logic [2:0] ACT_REAP      = 3'd5;
  localparam logic [2:0] ACT_QUERY     = 3'd6;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT   = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_REFUSED   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_SCHED_ENABLE  = 1'b0;
  localparam logic CFG_QUANTUM_TICKS = 1'b1;

  localparam logic [7:0] QUANTUM_RESET = 8'd5;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id;
    logic [31:0] ret_code;
  } tbl_entry_t;

endpackage

// ===== hdl/rrts_table.sv =====
`timescale 1ns / 1ps
module rrts_table
  import rrts_pkg::*;
#(
  parameter int NUM_SLOTS = 8,
  localparam int SLOT_W = $clog2(NUM_SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output tbl_entry_t        rd_data,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  tbl_entry_t        wr_data
);

  tbl_entry_t            mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  valid;
  tbl_entry_t            rd_raw;
  logic                  rd_valid;
  logic                  rd_kernel;

  // Write the entry and mark it valid
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read with its valid flag
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw    <= mem[rd_addr];
      rd_valid  <= valid[rd_addr];
      rd_kernel <= (rd_addr == '0);
    end
  end

  // Unwritten entries read as their reset value
  always_comb begin
    if (rd_valid) begin
      rd_data = rd_raw;
    end else begin
      rd_data.status   = rd_kernel ? SLOT_RUNNING : SLOT_UNUSED;
      rd_data.id       = '0;
      rd_data.ret_code = '0;
    end
  end

endmodule

// ===== hdl/rrts_ptr_mem.sv =====
`timescale 1ns / 1ps
module rrts_ptr_mem
  import rrts_pkg::*;
#(
  parameter int NUM_SLOTS = 8,
  localparam int SLOT_W = $clog2(NUM_SLOTS)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [63:0]       rd_data,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  logic [63:0]       wr_data
);

  logic [63:0] mem [NUM_SLOTS];

  // Store saved pointers
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/round_robin_task_scheduler.sv =====
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in       in_valid / in_stall  action, stack_pointer, target_id, exit_value
// out      out_valid/out_stall  resume_pointer, switched, running_slot, new_id,
//                               status, exit_out, is_live
// cfg      cfg_write            cfg_index, cfg_data
//
// One transaction at a time; the slot table is read one entry per cycle.
// Exit and a successful terminate end with a sweep that wakes every blocked slot.
// Reset is synchronous; slot 0 runs as the kernel task afterwards.
// A stalled result holds in the output register; the next result waits behind it.
module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic [63:0]        stack_pointer,
  input  logic [31:0]        target_id,
  input  logic signed [31:0] exit_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        resume_pointer,
  output logic               switched,
  output logic [2:0]         running_slot,
  output logic [31:0]        new_id,
  output logic [1:0]         status,
  output logic signed [31:0] exit_out,
  output logic               is_live
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_TICK_CUR  = 10'b0000000010,
    S_TICK_SCAN = 10'b0000000100,
    S_PTR       = 10'b0000001000,
    S_CREATE    = 10'b0000010000,
    S_FIND      = 10'b0000100000,
    S_WAIT_CUR  = 10'b0001000000,
    S_EXIT      = 10'b0010000000,
    S_WAKE      = 10'b0100000000,
    S_DONE      = 10'b1000000000
  } state_t;

  state_t            state, state_next;
  logic              sched_enable;
  logic [7:0]        quantum_ticks;
  logic [SLOT_W-1:0] cur, cur_next;
  logic [SLOT_W-1:0] scan, scan_next;
  logic [7:0]        ticks_left, ticks_left_next;
  logic [31:0]       next_id, next_id_next;
  logic [2:0]        act, act_next;
  logic [63:0]       sp, sp_next;
  logic [31:0]       tid, tid_next;
  logic [31:0]       xval, xval_next;
  logic [63:0]       res_ptr, res_ptr_next;
  logic              res_sw, res_sw_next;
  logic [31:0]       res_id, res_id_next;
  logic [1:0]        res_status, res_status_next;
  logic [31:0]       res_exit, res_exit_next;
  logic              res_live, res_live_next;
  logic              out_load;

  logic              tbl_rd_en, tbl_we;
  logic [SLOT_W-1:0] tbl_rd_addr, tbl_wr_addr;
  tbl_entry_t        tbl_rd, tbl_wr;
  logic              ptr_rd_en, ptr_we;
  logic [SLOT_W-1:0] ptr_rd_addr, ptr_wr_addr;
  logic [63:0]       ptr_rd, ptr_wr;

  logic              need;
  logic [7:0]        tl_dec;
  logic              hit;

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] idx);
    return (idx == LAST_SLOT) ? '0 : idx + SLOT_W'(1);
  endfunction

  rrts_table #(.NUM_SLOTS(NUM_SLOTS)) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd),
    .wr_en   (tbl_we),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr)
  );

  rrts_ptr_mem #(.NUM_SLOTS(NUM_SLOTS)) u_ptr (
    .clk     (clk),
    .rd_en   (ptr_rd_en),
    .rd_addr (ptr_rd_addr),
    .rd_data (ptr_rd),
    .wr_en   (ptr_we),
    .wr_addr (ptr_wr_addr),
    .wr_data (ptr_wr)
  );

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);
  assign hit      = (tbl_rd.status != SLOT_UNUSED) && (tbl_rd.id == tid);
  assign tl_dec   = (ticks_left != 8'd0) ? ticks_left - 8'd1 : 8'd0;

  // Sequence one transaction through the slot table
  always_comb begin
    state_next      = state;
    cur_next        = cur;
    scan_next       = scan;
    ticks_left_next = ticks_left;
    next_id_next    = next_id;
    act_next        = act;
    sp_next         = sp;
    tid_next        = tid;
    xval_next       = xval;
    res_ptr_next    = res_ptr;
    res_sw_next     = res_sw;
    res_id_next     = res_id;
    res_status_next = res_status;
    res_exit_next   = res_exit;
    res_live_next   = res_live;
    tbl_rd_en       = 1'b0;
    tbl_rd_addr     = scan;
    tbl_we          = 1'b0;
    tbl_wr_addr     = scan;
    tbl_wr          = tbl_rd;
    ptr_rd_en       = 1'b0;
    ptr_rd_addr     = scan;
    ptr_we          = 1'b0;
    ptr_wr_addr     = cur;
    ptr_wr          = sp;
    need            = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          act_next        = action;
          sp_next         = stack_pointer;
          tid_next        = target_id;
          xval_next       = exit_value;
          res_ptr_next    = '0;
          res_sw_next     = 1'b0;
          res_id_next     = '0;
          res_status_next = STAT_OK;
          res_exit_next   = '0;
          res_live_next   = 1'b0;
          case (action)
            ACT_TICK: begin
              if (!sched_enable) begin
                res_ptr_next = stack_pointer;
                state_next   = S_DONE;
              end else begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = cur;
                state_next  = S_TICK_CUR;
              end
            end
            ACT_CREATE: begin
              scan_next   = SLOT_W'(1);
              tbl_rd_en   = 1'b1;
              tbl_rd_addr = SLOT_W'(1);
              state_next  = S_CREATE;
            end
            ACT_EXIT: begin
              if (cur == '0) begin
                res_status_next = STAT_REFUSED;
                state_next      = S_DONE;
              end else begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = cur;
                state_next  = S_EXIT;
              end
            end
            ACT_TERMINATE, ACT_WAIT, ACT_REAP, ACT_QUERY: begin
              scan_next   = '0;
              tbl_rd_en   = 1'b1;
              tbl_rd_addr = '0;
              state_next  = S_FIND;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_TICK_CUR: begin
        // Count down the quantum unless the current task must leave
        if (tbl_rd.status == SLOT_TERMINATED || tbl_rd.status == SLOT_BLOCKED) begin
          need = 1'b1;
        end else begin
          ticks_left_next = (tl_dec == 8'd0) ? quantum_ticks : tl_dec;
          need            = (tl_dec == 8'd0);
        end
        if (!need) begin
          res_ptr_next = sp;
          state_next   = S_DONE;
        end else begin
          ptr_we      = 1'b1;
          ptr_wr_addr = cur;
          ptr_wr      = sp;
          if (tbl_rd.status == SLOT_RUNNING) begin
            tbl_we        = 1'b1;
            tbl_wr_addr   = cur;
            tbl_wr.status = SLOT_READY;
          end
          scan_next   = wrap_inc(cur);
          tbl_rd_en   = 1'b1;
          tbl_rd_addr = wrap_inc(cur);
          state_next  = S_TICK_SCAN;
        end
      end
      S_TICK_SCAN: begin
        // Search round-robin for the next ready slot, ending at the current one
        if (tbl_rd.status == SLOT_READY) begin
          tbl_we          = 1'b1;
          tbl_wr_addr     = scan;
          tbl_wr.status   = SLOT_RUNNING;
          cur_next        = scan;
          ticks_left_next = quantum_ticks;
          res_sw_next     = (scan != cur);
          ptr_rd_en       = 1'b1;
          ptr_rd_addr     = scan;
          state_next      = S_PTR;
        end else if (scan == cur) begin
          res_ptr_next = sp;
          state_next   = S_DONE;
        end else begin
          scan_next   = wrap_inc(scan);
          tbl_rd_en   = 1'b1;
          tbl_rd_addr = wrap_inc(scan);
        end
      end
      S_PTR: begin
        res_ptr_next = ptr_rd;
        state_next   = S_DONE;
      end
      S_CREATE: begin
        if (tbl_rd.status == SLOT_UNUSED) begin
          tbl_we          = 1'b1;
          tbl_wr_addr     = scan;
          tbl_wr.status   = SLOT_READY;
          tbl_wr.id       = next_id;
          tbl_wr.ret_code = '0;
          ptr_we          = 1'b1;
          ptr_wr_addr     = scan;
          ptr_wr          = sp;
          res_id_next     = next_id;
          next_id_next    = (&next_id) ? 32'd1 : next_id + 32'd1;
          state_next      = S_DONE;
        end else if (scan == LAST_SLOT) begin
          res_status_next = STAT_NO_SLOT;
          state_next      = S_DONE;
        end else begin
          scan_next   = wrap_inc(scan);
          tbl_rd_en   = 1'b1;
          tbl_rd_addr = wrap_inc(scan);
        end
      end
      S_FIND: begin
        if (hit) begin
          state_next = S_DONE;
          case (act)
            ACT_TERMINATE: begin
              if (tbl_rd.id == '0) begin
                res_status_next = STAT_REFUSED;
              end else begin
                tbl_we        = 1'b1;
                tbl_wr_addr   = scan;
                tbl_wr.status = SLOT_TERMINATED;
                scan_next     = '0;
                tbl_rd_en     = 1'b1;
                tbl_rd_addr   = '0;
                state_next    = S_WAKE;
              end
            end
            ACT_WAIT: begin
              if (tbl_rd.status != SLOT_TERMINATED) begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = cur;
                state_next  = S_WAIT_CUR;
              end
            end
            ACT_REAP: begin
              if (tbl_rd.status == SLOT_TERMINATED) begin
                res_exit_next = tbl_rd.ret_code;
                tbl_we        = 1'b1;
                tbl_wr_addr   = scan;
                tbl_wr.status = SLOT_UNUSED;
              end else begin
                res_status_next = STAT_NOT_FOUND;
              end
            end
            ACT_QUERY: begin
              res_live_next = (tbl_rd.status == SLOT_RUNNING) ||
                              (tbl_rd.status == SLOT_READY);
            end
            default: begin
              res_status_next = STAT_OK;
            end
          endcase
        end else if (scan == LAST_SLOT) begin
          res_status_next = STAT_NOT_FOUND;
          state_next      = S_DONE;
        end else begin
          scan_next   = wrap_inc(scan);
          tbl_rd_en   = 1'b1;
          tbl_rd_addr = wrap_inc(scan);
        end
      end
      S_WAIT_CUR: begin
        tbl_we        = 1'b1;
        tbl_wr_addr   = cur;
        tbl_wr.status = SLOT_BLOCKED;
        state_next    = S_DONE;
      end
      S_EXIT: begin
        tbl_we          = 1'b1;
        tbl_wr_addr     = cur;
        tbl_wr.status   = SLOT_TERMINATED;
        tbl_wr.ret_code = xval;
        scan_next       = '0;
        tbl_rd_en       = 1'b1;
        tbl_rd_addr     = '0;
        state_next      = S_WAKE;
      end
      S_WAKE: begin
        // Wake every blocked slot, one entry a cycle
        if (tbl_rd.status == SLOT_BLOCKED) begin
          tbl_we        = 1'b1;
          tbl_wr_addr   = scan;
          tbl_wr.status = SLOT_READY;
        end
        if (scan == LAST_SLOT) begin
          state_next = S_DONE;
        end else begin
          scan_next   = wrap_inc(scan);
          tbl_rd_en   = 1'b1;
          tbl_rd_addr = wrap_inc(scan);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur        <= '0;
      ticks_left <= QUANTUM_RESET;
      next_id    <= 32'd1;
    end else begin
      state      <= state_next;
      cur        <= cur_next;
      ticks_left <= ticks_left_next;
      next_id    <= next_id_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sched_enable  <= 1'b0;
      quantum_ticks <= QUANTUM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SCHED_ENABLE:  sched_enable  <= cfg_data[0];
        CFG_QUANTUM_TICKS: quantum_ticks <= cfg_data;
        default: begin
          sched_enable <= sched_enable;
        end
      endcase
    end
  end

  // Transaction payload and result fields
  always_ff @(posedge clk) begin
    scan       <= scan_next;
    act        <= act_next;
    sp         <= sp_next;
    tid        <= tid_next;
    xval       <= xval_next;
    res_ptr    <= res_ptr_next;
    res_sw     <= res_sw_next;
    res_id     <= res_id_next;
    res_status <= res_status_next;
    res_exit   <= res_exit_next;
    res_live   <= res_live_next;
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      resume_pointer <= res_ptr;
      switched       <= res_sw;
      running_slot   <= 3'(cur);
      new_id         <= res_id;
      status         <= res_status;
      exit_out       <= res_exit;
      is_live        <= res_live;
    end
  end

`ifndef SYNTHESIS
  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    int'(cur) < NUM_SLOTS)
    else $error("current slot out of range");

  a_fail_no_pointer: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> resume_pointer == '0 && !switched)
    else $error("failed action carries a resume pointer");

  a_new_id_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_id != '0 |-> status == STAT_OK && !switched)
    else $error("new id given with a failure status");
`endif

endmodule

// ===== verif/tb_round_robin_task_scheduler.sv =====
`timescale 1ns / 1ps
module tb_round_robin_task_scheduler;
  import rrts_pkg::*;

  localparam int SLOTS       = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [63:0] resume_pointer;
    logic        switched;
    logic [2:0]  running_slot;
    logic [31:0] new_id;
    logic [1:0]  status;
    logic [31:0] exit_out;
    logic        is_live;
  } sched_result_t;

  // Task table mirror and the results it predicts
  class task_table_sb;
    logic [2:0]    slot_state [SLOTS];
    logic [31:0]   slot_tid   [SLOTS];
    logic [63:0]   slot_sp    [SLOTS];
    logic [31:0]   slot_code  [SLOTS];
    int unsigned   cur;
    logic [31:0]   id_next;
    logic [7:0]    ticks;
    logic          enable;
    logic [7:0]    quantum;
    sched_result_t pending_results [$];
    int            errors;

    function void clear();
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] = SLOT_UNUSED;
        slot_tid[i]   = '0;
        slot_sp[i]    = '0;
        slot_code[i]  = '0;
      end
      slot_state[0] = SLOT_RUNNING;
      cur     = 0;
      id_next = 32'd1;
      ticks   = QUANTUM_RESET;
      enable  = 1'b0;
      quantum = QUANTUM_RESET;
      errors  = 0;
    endfunction

    function int lookup(logic [31:0] id);
      for (int i = 0; i < SLOTS; i++)
        if (slot_state[i] != SLOT_UNUSED && slot_tid[i] == id) return i;
      return -1;
    endfunction

    function void wake_all();
      for (int i = 0; i < SLOTS; i++)
        if (slot_state[i] == SLOT_BLOCKED) slot_state[i] = SLOT_READY;
    endfunction

    function logic [63:0] tick(logic [63:0] sp, output logic sw);
      logic need;
      int   nxt;
      int   idx;
      sw   = 1'b0;
      need = 1'b0;
      nxt  = -1;
      if (!enable) return sp;
      if (slot_state[cur] == SLOT_TERMINATED || slot_state[cur] == SLOT_BLOCKED) begin
        need = 1'b1;
      end else begin
        if (ticks > 0) ticks--;
        if (ticks == 0) begin
          ticks = quantum;
          need  = 1'b1;
        end
      end
      if (!need) return sp;
      slot_sp[cur] = sp;
      if (slot_state[cur] == SLOT_RUNNING) slot_state[cur] = SLOT_READY;
      for (int i = 1; i <= SLOTS; i++) begin
        idx = (cur + i) % SLOTS;
        if (slot_state[idx] == SLOT_READY) begin
          nxt = idx;
          break;
        end
      end
      if (nxt < 0) begin
        if (slot_state[cur] == SLOT_READY) slot_state[cur] = SLOT_RUNNING;
        return sp;
      end
      slot_state[nxt] = SLOT_RUNNING;
      sw    = (nxt != cur);
      cur   = nxt;
      ticks = quantum;
      return slot_sp[nxt];
    endfunction

    // Work out the result of one accepted input transaction
    function void note_input(logic [2:0] act, logic [63:0] sp, logic [31:0] tid,
                             logic [31:0] xv);
      sched_result_t r;
      int s;
      r = '0;
      s = -1;
      case (act)
        ACT_TICK: r.resume_pointer = tick(sp, r.switched);
        ACT_CREATE: begin
          for (int i = 1; i < SLOTS; i++)
            if (slot_state[i] == SLOT_UNUSED) begin
              s = i;
              break;
            end
          if (s < 0) begin
            r.status = STAT_NO_SLOT;
          end else begin
            slot_tid[s]   = id_next;
            r.new_id      = id_next;
            id_next       = (id_next == ID_MAX) ? 32'd1 : id_next + 32'd1;
            slot_code[s]  = '0;
            slot_sp[s]    = sp;
            slot_state[s] = SLOT_READY;
          end
        end
        ACT_EXIT: begin
          if (cur == 0) begin
            r.status = STAT_REFUSED;
          end else begin
            slot_state[cur] = SLOT_TERMINATED;
            slot_code[cur]  = xv;
            wake_all();
          end
        end
        ACT_TERMINATE: begin
          s = lookup(tid);
          if (s < 0) r.status = STAT_NOT_FOUND;
          else if (slot_tid[s] == 0) r.status = STAT_REFUSED;
          else begin
            slot_state[s] = SLOT_TERMINATED;
            wake_all();
          end
        end
        ACT_WAIT: begin
          s = lookup(tid);
          if (s < 0) r.status = STAT_NOT_FOUND;
          else if (slot_state[s] != SLOT_TERMINATED) slot_state[cur] = SLOT_BLOCKED;
        end
        ACT_REAP: begin
          s = lookup(tid);
          if (s < 0 || slot_state[s] != SLOT_TERMINATED) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            r.exit_out    = slot_code[s];
            slot_state[s] = SLOT_UNUSED;
          end
        end
        ACT_QUERY: begin
          s = lookup(tid);
          if (s < 0) r.status = STAT_NOT_FOUND;
          else r.is_live = (slot_state[s] == SLOT_RUNNING || slot_state[s] == SLOT_READY);
        end
        default: ;
      endcase
      r.running_slot = cur[2:0];
      pending_results.push_back(r);
    endfunction

    function void compare(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    // Match one accepted result against the oldest prediction
    function void check_result(sched_result_t got);
      sched_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      compare("resume_pointer", e.resume_pointer, got.resume_pointer);
      compare("switched", e.switched, got.switched);
      compare("running_slot", e.running_slot, got.running_slot);
      compare("new_id", e.new_id, got.new_id);
      compare("status", e.status, got.status);
      compare("exit_out", e.exit_out, got.exit_out);
      compare("is_live", e.is_live, got.is_live);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic               cfg_index = 1'b0;
  logic [7:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         action = '0;
  logic [63:0]        stack_pointer = '0;
  logic [31:0]        target_id = '0;
  logic signed [31:0] exit_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [63:0]        resume_pointer;
  logic               switched;
  logic [2:0]         running_slot;
  logic [31:0]        new_id;
  logic [1:0]         status;
  logic signed [31:0] exit_out;
  logic               is_live;

  task_table_sb sb;
  int           cycles = 0;
  int           burst_left = 0;

  round_robin_task_scheduler #(.NUM_SLOTS(SLOTS)) i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall pattern: quiet, light and heavy stretches
  always @(posedge clk) begin
    case ((cycles / 300) % 3)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 6);
    endcase
  end

  // Take each result transaction to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({resume_pointer, switched, running_slot, new_id, status,
                       exit_out, is_live});
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Drop the input and let every outstanding transaction finish
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] val);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_SCHED_ENABLE) sb.enable = val[0];
    else sb.quantum = val;
  endtask

  // Present one input transaction, then idle between bursts
  task automatic send(logic [2:0] act, logic [63:0] sp, logic [31:0] tid,
                      logic [31:0] xv);
    in_valid      <= 1'b1;
    action        <= act;
    stack_pointer <= sp;
    target_id     <= tid;
    exit_value    <= xv;
    do @(posedge clk); while (in_stall);
    sb.note_input(act, sp, tid, xv);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ((cycles / 500) % 4 != 3) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [63:0] rand_sp();
    return {$urandom, $urandom};
  endfunction

  // Mostly ids that exist in the table, some kernel and arbitrary ids
  function automatic logic [31:0] pick_id();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return sb.slot_tid[$urandom_range(0, SLOTS - 1)];
    if (k == 7) return '0;
    if (k == 8) return ID_MAX;
    return $urandom;
  endfunction

  task automatic random_items(int n);
    int w;
    logic [2:0] act;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      if (w < 35) act = ACT_TICK;
      else if (w < 50) act = ACT_CREATE;
      else if (w < 60) act = ACT_EXIT;
      else if (w < 69) act = ACT_TERMINATE;
      else if (w < 78) act = ACT_WAIT;
      else if (w < 89) act = ACT_REAP;
      else if (w < 97) act = ACT_QUERY;
      else act = 3'd7;
      send(act, rand_sp(), pick_id(), $urandom);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Scheduler off: ticks pass the pointer through
    write_cfg(CFG_SCHED_ENABLE, 8'd0);
    send(ACT_TICK, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    send(ACT_TICK, '0, '0, '0);
    send(ACT_EXIT, '0, '0, 32'h8000_0000);
    send(ACT_TERMINATE, '0, '0, '0);
    send(ACT_TERMINATE, '0, ID_MAX, '0);
    send(ACT_QUERY, '0, '0, '0);
    send(ACT_QUERY, '0, 32'd77, '0);
    // Fill the table, one create too many
    for (int i = 0; i < SLOTS; i++) send(ACT_CREATE, rand_sp(), '0, '0);
    send(ACT_REAP, '0, 32'd1, '0);
    send(ACT_WAIT, '0, 32'd99, '0);

    // Scheduler on, quantum 1: reschedule on every tick
    write_cfg(CFG_SCHED_ENABLE, 8'd1);
    write_cfg(CFG_QUANTUM_TICKS, 8'd1);
    send(ACT_TICK, rand_sp(), '0, '0);
    send(ACT_EXIT, '0, '0, 32'h7FFF_FFFF);
    send(ACT_TICK, rand_sp(), '0, '0);
    send(ACT_REAP, '0, 32'd1, '0);
    send(ACT_WAIT, '0, 32'd3, '0);
    send(ACT_TICK, rand_sp(), '0, '0);
    send(ACT_TERMINATE, '0, 32'd3, '0);
    send(ACT_WAIT, '0, 32'd3, '0);
    send(ACT_REAP, '0, 32'd3, '0);
    send(ACT_QUERY, '0, 32'd4, '0);

    random_items(80);
    write_cfg(CFG_QUANTUM_TICKS, 8'd255);
    random_items(60);
    write_cfg(CFG_QUANTUM_TICKS, 8'd0);
    random_items(60);
    write_cfg(CFG_SCHED_ENABLE, 8'd0);
    random_items(40);
    write_cfg(CFG_SCHED_ENABLE, 8'd1);
    write_cfg(CFG_QUANTUM_TICKS, 8'($urandom_range(2, 6)));
    random_items(90);
    write_cfg(CFG_QUANTUM_TICKS, 8'($urandom_range(1, 255)));
    random_items(70);

    wait_drained();
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
